// ----- rtl/core/tcw_pkg.sv -----
// Package for the text console character writer: screen geometry, field widths,
// transaction and queue types, character codes and state encodings.
// No dependencies.
package tcw_pkg;

	localparam int unsigned COLUMNS = 80;
	localparam int unsigned ROWS    = 25;
	localparam int unsigned CELLS   = ROWS * COLUMNS;
	localparam int unsigned ADDR_W  = $clog2(CELLS);
	localparam int unsigned ROW_W   = 5;
	localparam int unsigned COL_W   = 7;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned ATTR_W  = 8;
	localparam int unsigned CELL_W  = CHAR_W + ATTR_W;
	localparam int unsigned TABW_W  = 5;
	localparam int unsigned CFGI_W  = 2;
	localparam int unsigned CFGD_W  = 8;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;
	localparam logic [TABW_W-1:0] TABW_RESET = 5'd4;

	typedef enum logic [1:0] {
		ACT_PUT  = 2'd0,
		ACT_SET  = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [CFGI_W-1:0] {
		CFG_ATTR = 2'd0,
		CFG_TABW = 2'd1
	} cfg_index_t;

	typedef enum logic [2:0] {
		K_NOP       = 3'd0,
		K_PUT       = 3'd1,
		K_BACKSPACE = 3'd2,
		K_TAB       = 3'd3,
		K_NEWLINE   = 3'd4,
		K_SET       = 3'd5,
		K_READ      = 3'd6
	} kind_t;

	typedef enum logic [3:0] {
		S_CLEAR     = 4'd0,
		S_IDLE      = 4'd1,
		S_DISPATCH  = 4'd2,
		S_READ_WAIT = 4'd3,
		S_BS_WRITE  = 4'd4,
		S_BS_READ   = 4'd5,
		S_BS_CHECK  = 4'd6,
		S_TAB_DIV   = 4'd7,
		S_TAB_FILL  = 4'd8,
		S_SCR_RD    = 4'd9,
		S_SCR_WR    = 4'd10,
		S_SCR_BLANK = 4'd11,
		S_DONE      = 4'd12
	} state_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [CHAR_W-1:0] char_code;
		logic [ROW_W-1:0]  target_row;
		logic [COL_W-1:0]  target_column;
	} cmd_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_column;
		logic [CHAR_W-1:0] cell_char;
		logic [ATTR_W-1:0] cell_attribute;
	} rsp_item_t;

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] char_code;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
	endfunction

endpackage

// ----- rtl/core/tcw_if.sv -----
// Channel interfaces of the text console character writer: command, response
// and configuration write. Depends on tcw_pkg.
interface tcw_cmd_if;
	logic                valid;
	logic                ready;
	tcw_pkg::cmd_item_t  item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface tcw_rsp_if;
	logic                valid;
	logic                ready;
	tcw_pkg::rsp_item_t  item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface tcw_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::CFGI_W-1:0]   index;
	logic [tcw_pkg::CFGD_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/tcw_ram.sv -----
// Generic single-port RAM with registered read data, read-before-write.
// No dependencies.
module tcw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- rtl/core/tcw_front.sv -----
// Front end: accepts command transactions, classifies them and queues them
// (two entries) for the back end. Depends on tcw_pkg and tcw_if.
module tcw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	tcw_cmd_if.sink              cmd,
	input  logic                 clearing,
	input  logic                 pop,
	output tcw_pkg::queue_head_t head
);

	tcw_pkg::cmd_t  cls;
	tcw_pkg::cmd_t  entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           row_ok;
	logic           col_ok;

	assign row_ok = cmd.item.target_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS);
	assign col_ok = cmd.item.target_column < tcw_pkg::COL_W'(tcw_pkg::COLUMNS);

	always_comb begin
		cls.kind      = tcw_pkg::K_NOP;
		cls.char_code = cmd.item.char_code;
		cls.row       = cmd.item.target_row;
		cls.col       = cmd.item.target_column;
		unique case (tcw_pkg::action_t'(cmd.item.action))
			tcw_pkg::ACT_PUT: begin
				priority if (cmd.item.char_code == tcw_pkg::CH_BACKSPACE) begin
					cls.kind = tcw_pkg::K_BACKSPACE;
				end else if (cmd.item.char_code == tcw_pkg::CH_TAB) begin
					cls.kind = tcw_pkg::K_TAB;
				end else if (cmd.item.char_code == tcw_pkg::CH_NEWLINE) begin
					cls.kind = tcw_pkg::K_NEWLINE;
				end else begin
					cls.kind = tcw_pkg::K_PUT;
				end
			end
			tcw_pkg::ACT_SET: begin
				cls.kind = tcw_pkg::K_SET;
				if (!row_ok) begin
					cls.row = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
				end
				if (!col_ok) begin
					cls.col = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
				end
			end
			tcw_pkg::ACT_READ: begin
				cls.kind = (row_ok && col_ok) ? tcw_pkg::K_READ : tcw_pkg::K_NOP;
			end
			tcw_pkg::ACT_NONE: begin
				cls.kind = tcw_pkg::K_NOP;
			end
			default: begin
				cls.kind = tcw_pkg::K_NOP;
			end
		endcase
	end

	assign cmd.ready  = (count_q != 2'd2) && !clearing;
	assign push       = cmd.valid && cmd.ready;
	assign head.valid = count_q != 2'd0;
	assign head.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

endmodule

// ----- rtl/core/tcw_back.sv -----
// Back end: sequencer that runs queued commands against the screen RAM, keeps
// the cursor, does the clearing pass and scrolling, and holds the response
// register. Depends on tcw_pkg, tcw_if and tcw_ram.
module tcw_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcw_pkg::queue_head_t        head,
	output logic                        pop,
	output logic                        clearing,
	input  logic [tcw_pkg::ATTR_W-1:0]  text_attr,
	input  logic [tcw_pkg::TABW_W-1:0]  tab_width,
	tcw_rsp_if.source                   rsp
);

	typedef struct packed {
		logic                         we;
		logic [tcw_pkg::ADDR_W-1:0]   addr;
		logic [tcw_pkg::CELL_W-1:0]   wdata;
		logic                         pop;
		logic                         load;
		logic                         nl;
		logic                         adv;
		logic                         back;
		logic                         set;
		logic                         idx_inc;
		logic                         div_start;
		logic                         div_step;
		logic                         fill_dec;
		logic                         cap_read;
		logic                         clr_res;
	} ctl_t;

	localparam int unsigned DIVC_W = $clog2(tcw_pkg::ADDR_W);

	tcw_pkg::state_t             state_q;
	tcw_pkg::state_t             state_nx;
	ctl_t                        ctl;
	tcw_pkg::cmd_t               cmd_s1;
	logic [tcw_pkg::ROW_W-1:0]   cur_row_q;
	logic [tcw_pkg::COL_W-1:0]   cur_col_q;
	logic [tcw_pkg::ADDR_W-1:0]  idx_q;
	logic [tcw_pkg::TABW_W-1:0]  rem_q;
	logic [DIVC_W-1:0]           div_cnt_q;
	logic [tcw_pkg::TABW_W-1:0]  fill_q;
	logic [tcw_pkg::CHAR_W-1:0]  res_char_q;
	logic [tcw_pkg::ATTR_W-1:0]  res_attr_q;
	logic                        rsp_valid_q;
	tcw_pkg::rsp_item_t          rsp_item_q;
	logic [tcw_pkg::CELL_W-1:0]  rdata;

	logic [tcw_pkg::ADDR_W-1:0]  pos;
	logic                        at_last_col;
	logic                        at_last_row;
	logic [tcw_pkg::TABW_W-1:0]  tw;
	logic [tcw_pkg::TABW_W:0]    trial;
	logic [tcw_pkg::TABW_W-1:0]  rem_nx;
	logic [tcw_pkg::TABW_W-1:0]  fill_raw;
	logic [tcw_pkg::COL_W-1:0]   room;
	logic [tcw_pkg::TABW_W-1:0]  fill_lim;
	logic [tcw_pkg::CELL_W-1:0]  blank;
	logic                        rsp_free;
	logic                        prev_empty;

	assign pos         = tcw_pkg::cell_addr(cur_row_q, cur_col_q);
	assign at_last_col = cur_col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
	assign at_last_row = cur_row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
	assign tw          = (tab_width == '0) ? tcw_pkg::TABW_W'(1) : tab_width;
	assign trial       = {rem_q, pos[div_cnt_q]};
	assign rem_nx      = (trial >= {1'b0, tw}) ? tcw_pkg::TABW_W'(trial - {1'b0, tw})
		: trial[tcw_pkg::TABW_W-1:0];
	assign fill_raw    = tw - rem_nx;
	assign room        = tcw_pkg::COL_W'(tcw_pkg::COLUMNS) - cur_col_q;
	assign fill_lim    = (tcw_pkg::COL_W'(fill_raw) < room) ? fill_raw
		: room[tcw_pkg::TABW_W-1:0];
	assign blank       = {text_attr, tcw_pkg::CH_BLANK};
	assign rsp_free    = !rsp_valid_q || rsp.ready;
	assign prev_empty  = (rdata[tcw_pkg::CHAR_W-1:0] == tcw_pkg::CH_NUL)
		|| (rdata[tcw_pkg::CHAR_W-1:0] == tcw_pkg::CH_BLANK);

	tcw_ram #(
		.WIDTH (tcw_pkg::CELL_W),
		.DEPTH (tcw_pkg::CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ctl.we),
		.addr  (ctl.addr),
		.wdata (ctl.wdata),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tcw_pkg::S_CLEAR: begin
				if (idx_q == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
					state_nx = tcw_pkg::S_IDLE;
				end
			end
			tcw_pkg::S_IDLE: begin
				if (head.valid) begin
					state_nx = tcw_pkg::S_DISPATCH;
				end
			end
			tcw_pkg::S_DISPATCH: begin
				unique case (cmd_s1.kind)
					tcw_pkg::K_PUT: begin
						state_nx = (at_last_col && at_last_row) ? tcw_pkg::S_SCR_RD
							: tcw_pkg::S_DONE;
					end
					tcw_pkg::K_NEWLINE: begin
						state_nx = at_last_row ? tcw_pkg::S_SCR_RD : tcw_pkg::S_DONE;
					end
					tcw_pkg::K_TAB:       state_nx = tcw_pkg::S_TAB_DIV;
					tcw_pkg::K_BACKSPACE: begin
						state_nx = (pos == '0) ? tcw_pkg::S_DONE : tcw_pkg::S_BS_WRITE;
					end
					tcw_pkg::K_READ:      state_nx = tcw_pkg::S_READ_WAIT;
					default:              state_nx = tcw_pkg::S_DONE;
				endcase
			end
			tcw_pkg::S_READ_WAIT: state_nx = tcw_pkg::S_DONE;
			tcw_pkg::S_BS_WRITE: begin
				state_nx = (pos == tcw_pkg::ADDR_W'(1)) ? tcw_pkg::S_DONE
					: tcw_pkg::S_BS_READ;
			end
			tcw_pkg::S_BS_READ: state_nx = tcw_pkg::S_BS_CHECK;
			tcw_pkg::S_BS_CHECK: begin
				state_nx = prev_empty ? tcw_pkg::S_BS_WRITE : tcw_pkg::S_DONE;
			end
			tcw_pkg::S_TAB_DIV: begin
				if (div_cnt_q == '0) begin
					state_nx = tcw_pkg::S_TAB_FILL;
				end
			end
			tcw_pkg::S_TAB_FILL: begin
				priority if (at_last_col) begin
					state_nx = at_last_row ? tcw_pkg::S_SCR_RD : tcw_pkg::S_DONE;
				end else if (fill_q == tcw_pkg::TABW_W'(1)) begin
					state_nx = tcw_pkg::S_DONE;
				end else begin
					state_nx = tcw_pkg::S_TAB_FILL;
				end
			end
			tcw_pkg::S_SCR_RD: state_nx = tcw_pkg::S_SCR_WR;
			tcw_pkg::S_SCR_WR: begin
				state_nx = (idx_q == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS - 1))
					? tcw_pkg::S_SCR_BLANK : tcw_pkg::S_SCR_RD;
			end
			tcw_pkg::S_SCR_BLANK: begin
				if (idx_q == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
					state_nx = tcw_pkg::S_DONE;
				end
			end
			tcw_pkg::S_DONE: begin
				if (rsp_free) begin
					state_nx = tcw_pkg::S_IDLE;
				end
			end
			default: state_nx = tcw_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl       = '0;
		ctl.addr  = pos;
		ctl.wdata = blank;
		unique case (state_q)
			tcw_pkg::S_CLEAR: begin
				ctl.we      = 1'b1;
				ctl.addr    = idx_q;
				ctl.wdata   = '0;
				ctl.idx_inc = 1'b1;
			end
			tcw_pkg::S_IDLE: begin
				ctl.pop = head.valid;
			end
			tcw_pkg::S_DISPATCH: begin
				ctl.clr_res = 1'b1;
				unique case (cmd_s1.kind)
					tcw_pkg::K_PUT: begin
						ctl.we    = 1'b1;
						ctl.wdata = {text_attr, cmd_s1.char_code};
						ctl.nl    = at_last_col;
						ctl.adv   = !at_last_col;
					end
					tcw_pkg::K_NEWLINE: ctl.nl = 1'b1;
					tcw_pkg::K_TAB:     ctl.div_start = 1'b1;
					tcw_pkg::K_SET:     ctl.set = 1'b1;
					tcw_pkg::K_READ:    ctl.addr = tcw_pkg::cell_addr(cmd_s1.row, cmd_s1.col);
					default: begin
					end
				endcase
			end
			tcw_pkg::S_READ_WAIT: ctl.cap_read = 1'b1;
			tcw_pkg::S_BS_WRITE: begin
				ctl.we   = 1'b1;
				ctl.addr = pos - tcw_pkg::ADDR_W'(1);
				ctl.back = 1'b1;
			end
			tcw_pkg::S_BS_READ: ctl.addr = pos - tcw_pkg::ADDR_W'(1);
			tcw_pkg::S_TAB_DIV: ctl.div_step = 1'b1;
			tcw_pkg::S_TAB_FILL: begin
				ctl.we       = 1'b1;
				ctl.nl       = at_last_col;
				ctl.adv      = !at_last_col;
				ctl.fill_dec = 1'b1;
			end
			tcw_pkg::S_SCR_RD: begin
				ctl.addr = tcw_pkg::ADDR_W'(idx_q + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS));
			end
			tcw_pkg::S_SCR_WR: begin
				ctl.we      = 1'b1;
				ctl.addr    = idx_q;
				ctl.wdata   = rdata;
				ctl.idx_inc = 1'b1;
			end
			tcw_pkg::S_SCR_BLANK: begin
				ctl.we      = 1'b1;
				ctl.addr    = idx_q;
				ctl.idx_inc = 1'b1;
			end
			tcw_pkg::S_DONE: ctl.load = rsp_free;
			default: begin
			end
		endcase
	end

	assign pop      = ctl.pop;
	assign clearing = state_q == tcw_pkg::S_CLEAR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::S_CLEAR;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			priority if (ctl.set) begin
				cur_row_q <= cmd_s1.row;
				cur_col_q <= cmd_s1.col;
			end else if (ctl.nl) begin
				cur_col_q <= '0;
				if (!at_last_row) begin
					cur_row_q <= cur_row_q + tcw_pkg::ROW_W'(1);
				end
			end else if (ctl.adv) begin
				cur_col_q <= cur_col_q + tcw_pkg::COL_W'(1);
			end else if (ctl.back) begin
				if (cur_col_q == '0) begin
					cur_col_q <= tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
					cur_row_q <= cur_row_q - tcw_pkg::ROW_W'(1);
				end else begin
					cur_col_q <= cur_col_q - tcw_pkg::COL_W'(1);
				end
			end else begin
				cur_row_q <= cur_row_q;
				cur_col_q <= cur_col_q;
			end
			if (ctl.nl) begin
				idx_q <= '0;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + tcw_pkg::ADDR_W'(1);
			end
			if (ctl.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			cmd_s1 <= head.cmd;
		end
		if (ctl.div_start) begin
			rem_q     <= '0;
			div_cnt_q <= DIVC_W'(tcw_pkg::ADDR_W - 1);
		end else if (ctl.div_step) begin
			rem_q     <= rem_nx;
			div_cnt_q <= div_cnt_q - DIVC_W'(1);
		end
		if (ctl.div_step && (div_cnt_q == '0)) begin
			fill_q <= fill_lim;
		end else if (ctl.fill_dec) begin
			fill_q <= fill_q - tcw_pkg::TABW_W'(1);
		end
		if (ctl.clr_res) begin
			res_char_q <= '0;
			res_attr_q <= '0;
		end else if (ctl.cap_read) begin
			res_char_q <= rdata[tcw_pkg::CHAR_W-1:0];
			res_attr_q <= rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
		end
		if (ctl.load) begin
			rsp_item_q.cursor_row     <= cur_row_q;
			rsp_item_q.cursor_column  <= cur_col_q;
			rsp_item_q.cell_char      <= res_char_q;
			rsp_item_q.cell_attribute <= res_attr_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.item  = rsp_item_q;

`ifndef ASSERT_OFF
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_row_q < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
		else $error("cursor row out of range");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q < tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
		else $error("cursor column out of range");
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.we |-> (ctl.addr < tcw_pkg::ADDR_W'(tcw_pkg::CELLS)))
		else $error("screen write beyond last cell");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop)
		else $error("queue popped during clearing pass");
	a_fill_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::S_TAB_FILL) |-> (fill_q != '0))
		else $error("tab fill with zero count");
`endif

endmodule

// ----- rtl/core/text_console_char_writer_unit.sv -----
// Top level of the text console character writer: configuration registers,
// front end (accept, classify, queue) and back end (screen sequencer).
// Depends on tcw_pkg, tcw_if, tcw_front, tcw_back.
//
// Usage: commands enter on cmd (valid/ready), one response per command leaves
// on rsp (valid/ready). cfg writes text_attribute (index 0) and tab_width
// (index 1) and is always ready; the user must write it only while the block
// is idle, which the block itself does not enforce. A tab runs an 11-step
// remainder unit and then writes its blanks. Backspace steps back one cell at
// a time. Any wrap or newline on the last row scrolls the screen through the
// single-port screen RAM. Commands are processed one at a time; a two-entry
// queue lets up to two commands be accepted while the back end is busy.
// After reset a clearing pass zeroes all CELLS (2000) cells, one per cycle;
// cmd.ready stays low until it ends. Cursor resets to row 0, column 0.
// A stalled rsp holds its response; the back end keeps working and stops only
// when it has the next response ready and the response register is still full.
module text_console_char_writer_unit (
	input  logic      clk,
	input  logic      arst_n,
	tcw_cmd_if.sink   cmd,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink   cfg
);

	logic [tcw_pkg::ATTR_W-1:0]  attr_q;
	logic [tcw_pkg::TABW_W-1:0]  tabw_q;
	tcw_pkg::queue_head_t        head;
	logic                        pop;
	logic                        clearing;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
			tabw_q <= tcw_pkg::TABW_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				tcw_pkg::CFG_ATTR: attr_q <= cfg.data[tcw_pkg::ATTR_W-1:0];
				tcw_pkg::CFG_TABW: tabw_q <= cfg.data[tcw_pkg::TABW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tcw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.clearing (clearing),
		.pop      (pop),
		.head     (head)
	);

	tcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.clearing  (clearing),
		.text_attr (attr_q),
		.tab_width (tabw_q),
		.rsp       (rsp)
	);

endmodule
